>>> rtl/slip_frame_receiver_crc16_unit_defines.svh
// assertion macros for the top file, which checks itself
`ifndef SLIP_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH
`define SLIP_FRAME_RECEIVER_CRC16_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SFRC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfrc check failed: same cycle");

// next-cycle implication, disabled while reset is low
`define SFRC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfrc check failed: next cycle");

`endif

>>> rtl/sfrc_pkg.sv
package sfrc_pkg;

    // frame size limit and counter widths
    localparam int MAX_FRAME = 4096;
    localparam int LEN_W     = $clog2(MAX_FRAME + 2);
    localparam int FLEN_W    = 13;
    localparam logic [LEN_W-1:0] RAW_LIMIT = LEN_W'(MAX_FRAME);

    // queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // status codes
    localparam logic [2:0] ST_GOOD     = 3'd0;
    localparam logic [2:0] ST_CRC_ERR  = 3'd1;
    localparam logic [2:0] ST_LEN_ERR  = 3'd2;
    localparam logic [2:0] ST_BAD_ESC  = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    // one entry of the queue: a data byte or an end-of-frame summary
    typedef struct packed {
        logic              is_end;
        logic [7:0]        data;
        logic [FLEN_W-1:0] len;
        logic [2:0]        pre_status;  // too long, short or bad escape, else good
        logic              few_bytes;   // fewer than two unescaped bytes
        logic              len_bad;     // length field check failed
        logic [15:0]       rx_crc;
    } sfrc_item_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } sfrc_qstat_t;

endpackage

>>> rtl/sfrc_front.sv
module sfrc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  sfrc_pkg::sfrc_qstat_t qstat,
    output logic                 push,
    output sfrc_pkg::sfrc_item_t push_item
);

    localparam logic [7:0] FRAME_END = 8'hC0;
    localparam logic [7:0] ESC       = 8'hDB;
    localparam logic [7:0] ESC_END   = 8'hDC;
    localparam logic [7:0] ESC_ESC   = 8'hDD;
    localparam int         LW        = sfrc_pkg::LEN_W;

    localparam logic [LW-1:0] RAW_LIMIT_C = sfrc_pkg::RAW_LIMIT;

    logic          in_frame_reg, in_frame_next;
    logic          esc_reg, esc_next;
    logic          bad_esc_reg, bad_esc_next;
    logic [LW-1:0] raw_cnt_reg, raw_cnt_next;
    logic [LW-1:0] unesc_cnt_reg, unesc_cnt_next;
    logic [7:0]    held0_reg, held0_next;
    logic [7:0]    held1_reg, held1_next;
    logic [15:0]   len_field_reg, len_field_next;

    logic          accept;
    logic [LW-1:0] raw_inc;
    logic [7:0]    ubyte;
    logic          have_byte;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    // frame tracking, unescaping and the two-byte hold line
    always_comb begin
        in_frame_next  = in_frame_reg;
        esc_next       = esc_reg;
        bad_esc_next   = bad_esc_reg;
        raw_cnt_next   = raw_cnt_reg;
        unesc_cnt_next = unesc_cnt_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        len_field_next = len_field_reg;
        push           = 1'b0;
        push_item      = '0;
        ubyte          = s_tdata;
        have_byte      = 1'b0;
        raw_inc        = (raw_cnt_reg <= RAW_LIMIT_C) ? raw_cnt_reg + LW'(1) : raw_cnt_reg;

        if (accept) begin
            if (s_tdata == FRAME_END) begin
                // close the frame in progress with a summary entry
                if (in_frame_reg && raw_cnt_reg != '0) begin
                    push                 = 1'b1;
                    push_item.is_end     = 1'b1;
                    push_item.len        = (unesc_cnt_reg >= LW'(2))
                                         ? sfrc_pkg::FLEN_W'(unesc_cnt_reg - LW'(2)) : '0;
                    push_item.rx_crc     = {held0_reg, held1_reg};
                    push_item.few_bytes  = unesc_cnt_reg < LW'(2);
                    push_item.len_bad    = (unesc_cnt_reg < LW'(6))
                                         || (len_field_reg != 16'(unesc_cnt_reg - LW'(6)));
                    if (raw_cnt_reg > RAW_LIMIT_C) begin
                        push_item.pre_status = sfrc_pkg::ST_TOO_LONG;
                    end else if (raw_cnt_reg < LW'(6)) begin
                        push_item.pre_status = sfrc_pkg::ST_SHORT;
                    end else if (bad_esc_reg || esc_reg) begin
                        push_item.pre_status = sfrc_pkg::ST_BAD_ESC;
                    end else begin
                        push_item.pre_status = sfrc_pkg::ST_GOOD;
                    end
                end
                // open a fresh frame unless the current one is still empty
                if (!in_frame_reg || raw_cnt_reg != '0) begin
                    in_frame_next  = 1'b1;
                    esc_next       = 1'b0;
                    bad_esc_next   = 1'b0;
                    raw_cnt_next   = '0;
                    unesc_cnt_next = '0;
                    held0_next     = '0;
                    held1_next     = '0;
                    len_field_next = '0;
                end
            end else if (in_frame_reg) begin
                raw_cnt_next = raw_inc;
                if (raw_inc <= RAW_LIMIT_C) begin
                    if (esc_reg) begin
                        esc_next  = 1'b0;
                        have_byte = 1'b1;
                        if (s_tdata == ESC_END) begin
                            ubyte = FRAME_END;
                        end else if (s_tdata == ESC_ESC) begin
                            ubyte = ESC;
                        end else begin
                            bad_esc_next = 1'b1;
                        end
                    end else if (s_tdata == ESC) begin
                        esc_next = 1'b1;
                    end else begin
                        have_byte = 1'b1;
                    end
                end
                if (have_byte) begin
                    // bytes 2 and 3 carry the big-endian length field
                    if (unesc_cnt_reg == LW'(2)) begin
                        len_field_next = {ubyte, 8'h00};
                    end else if (unesc_cnt_reg == LW'(3)) begin
                        len_field_next = {len_field_reg[15:8], ubyte};
                    end
                    if (unesc_cnt_reg >= LW'(2)) begin
                        push           = 1'b1;
                        push_item.data = held0_reg;
                        push_item.len  = sfrc_pkg::FLEN_W'(unesc_cnt_reg - LW'(1));
                    end
                    held0_next     = held1_reg;
                    held1_next     = ubyte;
                    unesc_cnt_next = unesc_cnt_reg + LW'(1);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            bad_esc_reg   <= 1'b0;
            raw_cnt_reg   <= '0;
            unesc_cnt_reg <= '0;
            held0_reg     <= '0;
            held1_reg     <= '0;
            len_field_reg <= '0;
        end else begin
            in_frame_reg  <= in_frame_next;
            esc_reg       <= esc_next;
            bad_esc_reg   <= bad_esc_next;
            raw_cnt_reg   <= raw_cnt_next;
            unesc_cnt_reg <= unesc_cnt_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            len_field_reg <= len_field_next;
        end
    end

endmodule

>>> rtl/sfrc_fifo.sv
module sfrc_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sfrc_pkg::sfrc_item_t  push_item,
    input  logic                  pop,
    output sfrc_pkg::sfrc_item_t  pop_item,
    output sfrc_pkg::sfrc_qstat_t qstat
);

    localparam int PW = sfrc_pkg::QPTR_W;
    localparam int CW = sfrc_pkg::QCNT_W;

    sfrc_pkg::sfrc_item_t slots_reg [sfrc_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign qstat.full  = count_reg == CW'(sfrc_pkg::QDEPTH);
    assign qstat.empty = count_reg == '0;
    assign pop_item    = slots_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/sfrc_back.sv
module sfrc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sfrc_pkg::sfrc_item_t  pop_item,
    input  sfrc_pkg::sfrc_qstat_t qstat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // [7:0] out_byte, [10:8] status, [23:11] frame_length
    output logic                  m_tlast   // is_end
);

    localparam logic [15:0] CRC_POLY = 16'h8005;

    logic        valid_reg, valid_next;
    logic [23:0] data_reg;
    logic        last_reg;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  end_status;

    // one byte of crc-16, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign pop      = !qstat.empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    // final status of a closing frame
    always_comb begin
        if (pop_item.pre_status != sfrc_pkg::ST_GOOD) begin
            end_status = pop_item.pre_status;
        end else if (pop_item.few_bytes || pop_item.rx_crc != crc_reg) begin
            end_status = sfrc_pkg::ST_CRC_ERR;
        end else if (pop_item.len_bad) begin
            end_status = sfrc_pkg::ST_LEN_ERR;
        end else begin
            end_status = sfrc_pkg::ST_GOOD;
        end
    end

    // crc runs over data entries and restarts after each summary
    always_comb begin
        crc_next = crc_reg;
        if (pop) begin
            crc_next = pop_item.is_end ? 16'h0000 : crc_byte(crc_reg, pop_item.data);
        end
        valid_next = pop ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            crc_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            crc_reg   <= crc_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (pop) begin
            last_reg <= pop_item.is_end;
            if (pop_item.is_end) begin
                data_reg <= {pop_item.len, end_status, 8'h00};
            end else begin
                data_reg <= {pop_item.len, sfrc_pkg::ST_GOOD, pop_item.data};
            end
        end
    end

endmodule

>>> rtl/slip_frame_receiver_crc16_unit.sv
// channel   dir   tdata fields (low bit up)                      tlast
// s_        in    in_byte[7:0]                                   -
// m_        out   out_byte[7:0] status[10:8] frame_length[23:11] is_end
//
// one raw byte is taken per cycle while the queue has room; a result leaves
// through a four-entry queue and a registered output stage.
// the front stalls (s_tready low) only while the queue is full.
// crc updates one whole byte per cycle; both sides run one item a cycle unless stalled.
// reset: aresetn synchronous, active low; hunts for the first delimiter afterwards.
`include "slip_frame_receiver_crc16_unit_defines.svh"

module slip_frame_receiver_crc16_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [10:8] status, [23:11] frame_length
    output logic        m_tlast    // is_end
);

    sfrc_pkg::sfrc_item_t  push_item;
    sfrc_pkg::sfrc_item_t  pop_item;
    sfrc_pkg::sfrc_qstat_t qstat;
    logic                  push;
    logic                  pop;
    logic [2:0]            m_status;
    logic                  data_fields_ok;
    logic                  status_fields_ok;

    // deframing and classification
    sfrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    sfrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    // crc check and output stage
    sfrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_item (pop_item),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // output field checks
    assign m_status         = m_tdata[10:8];
    assign data_fields_ok   = (m_status == sfrc_pkg::ST_GOOD) && (m_tdata[23:11] != '0);
    assign status_fields_ok = (m_status <= sfrc_pkg::ST_TOO_LONG) && (m_tdata[7:0] == 8'h00);

    // checks
    `SFRC_ASSERT_NOW(a_no_push_full, aclk, aresetn, push, !qstat.full)
    `SFRC_ASSERT_NEXT(a_pop_fills_out, aclk, aresetn, !qstat.empty && m_tready, m_tvalid)
    `SFRC_ASSERT_NOW(a_data_item_fields, aclk, aresetn, m_tvalid && !m_tlast, data_fields_ok)
    `SFRC_ASSERT_NOW(a_status_range, aclk, aresetn, m_tvalid && m_tlast, status_fields_ok)

endmodule
